// ===== rtl/core/indexed_list_engine_assert.svh =====
// Assertion macros for the indexed list engine.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ILE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed list engine: same-cycle check failed");

// Next-cycle implication.
`define ILE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed list engine: next-cycle check failed");

`else

`define ILE_ASSERT_IMP(label, ante, cons)
`define ILE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/ile_pkg.sv =====
package ile_pkg;

  // List geometry
  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  // Width used to compare a clamped position against the count
  localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;

  // Operation codes on the input channel
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_PEEK   = 2'd2;

  // Status codes on the result channel
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [7:0]  position;
    logic signed [31:0] item_value;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         list_length;
  } out_item_t;

  // Shift direction applied by the cell row
  typedef enum logic {
    SHIFT_INSERT,
    SHIFT_REMOVE
  } shift_kind_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic              wr_en;
    shift_kind_t       kind;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== rtl/core/ile_cell.sv =====
module ile_cell (
  input  logic                      clk,
  input  logic [ile_pkg::IDX_W-1:0] idx,
  input  ile_pkg::cell_cmd_t        cmd,
  input  logic [ile_pkg::DATA_W-1:0] left_q,
  input  logic [ile_pkg::DATA_W-1:0] right_q,
  output logic [ile_pkg::DATA_W-1:0] q,
  output logic [ile_pkg::DATA_W-1:0] rd
);

  logic [ile_pkg::DATA_W-1:0] q_r;
  logic [ile_pkg::DATA_W-1:0] q_nxt;

  // Insert: cells past the position take the left neighbor, the target takes the value.
  // Remove: cells at or past the position take the right neighbor.
  always_comb begin
    q_nxt = q_r;
    if (cmd.wr_en) begin
      unique case (cmd.kind)
        ile_pkg::SHIFT_INSERT: begin
          if (idx > cmd.pos) begin
            q_nxt = left_q;
          end else if (idx == cmd.pos) begin
            q_nxt = cmd.value;
          end
        end
        ile_pkg::SHIFT_REMOVE: begin
          if (idx >= cmd.pos) begin
            q_nxt = right_q;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q  = q_r;
  // Contribute the stored entry to the read bus when addressed
  assign rd = (idx == cmd.pos) ? q_r : '0;

endmodule

// ===== rtl/core/ile_chain.sv =====
module ile_chain (
  input  logic                       clk,
  input  ile_pkg::cell_cmd_t         cmd,
  output logic [ile_pkg::DATA_W-1:0] rd_data
);

  logic [ile_pkg::DATA_W-1:0] cell_q  [ile_pkg::CAPACITY];
  logic [ile_pkg::DATA_W-1:0] cell_rd [ile_pkg::CAPACITY];

  // Row of cells, each wired to its two neighbors
  for (genvar i = 0; i < ile_pkg::CAPACITY; i++) begin : g_cell
    logic [ile_pkg::DATA_W-1:0] left_q;
    logic [ile_pkg::DATA_W-1:0] right_q;

    if (i == 0) begin : g_head
      assign left_q = '0;
    end else begin : g_left
      assign left_q = cell_q[i-1];
    end

    if (i == ile_pkg::CAPACITY - 1) begin : g_tail
      assign right_q = '0;
    end else begin : g_right
      assign right_q = cell_q[i+1];
    end

    ile_cell u_cell (
      .clk     (clk),
      .idx     (ile_pkg::IDX_W'(i)),
      .cmd     (cmd),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[i]),
      .rd      (cell_rd[i])
    );
  end

  // One-hot read: only the addressed cell drives a nonzero word
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < ile_pkg::CAPACITY; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

endmodule

// ===== rtl/core/indexed_list_engine.sv =====
// Channel  Direction  Handshake         Payload
// in_      input      in_valid/in_stall   ile_pkg::in_item_t
// out_     output     out_valid/out_stall ile_pkg::out_item_t
//
// Each transaction is held in a decode register with its position clamped
// against the count, then the cell row shifts and the addressed entry is read.
// No new transaction is accepted while one is held in the decode register.
// Synchronous active-low reset empties the list; entry contents are not cleared.
// A stalled result holds the output register and blocks further input.
module indexed_list_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ile_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ile_pkg::out_item_t out_data
);

  logic                       in_acc;
  logic [ile_pkg::CNT_W-1:0]  count_r;
  logic [ile_pkg::CNT_W-1:0]  count_nxt;

  // Decode stage
  logic                       exe_valid_r;
  ile_pkg::cell_cmd_t         exe_cmd_r;
  ile_pkg::cell_cmd_t         exe_cmd_nxt;
  logic                       exe_rd_r;
  logic                       exe_rd_nxt;
  logic [1:0]                 exe_status_r;
  logic [1:0]                 exe_status_nxt;
  logic [6:0]                 exe_len_r;

  // Output stage
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  ile_pkg::out_item_t         out_data_r;

  // Chain interface
  ile_pkg::cell_cmd_t         chain_cmd;
  logic [ile_pkg::DATA_W-1:0] chain_rd;

  // Position clamping
  logic                       pos_neg;
  logic [ile_pkg::CMP_W-1:0]  pos_u;
  logic [ile_pkg::CMP_W-1:0]  cnt_w;
  logic [ile_pkg::CMP_W-1:0]  ins_pos;
  logic [ile_pkg::CMP_W-1:0]  rm_pos;
  logic                       full;
  logic                       empty;

  // Accept only when the decode stage is empty and the output can take a result
  assign in_stall = exe_valid_r | (out_valid_r & out_stall);
  assign in_acc   = in_valid & ~in_stall;

  assign pos_neg = in_data.position[7];
  assign pos_u   = ile_pkg::CMP_W'(in_data.position[6:0]);
  assign cnt_w   = ile_pkg::CMP_W'(count_r);
  assign full    = (count_r == ile_pkg::CNT_W'(ile_pkg::CAPACITY));
  assign empty   = (count_r == '0);

  assign ins_pos = pos_neg ? '0 : ((pos_u > cnt_w) ? cnt_w : pos_u);
  assign rm_pos  = pos_neg ? '0 : ((pos_u >= cnt_w) ? (cnt_w - 1'b1) : pos_u);

  // Operation decode
  always_comb begin
    exe_cmd_nxt.wr_en = 1'b0;
    exe_cmd_nxt.kind  = ile_pkg::SHIFT_INSERT;
    exe_cmd_nxt.pos   = '0;
    exe_cmd_nxt.value = in_data.item_value;
    exe_rd_nxt        = 1'b0;
    exe_status_nxt    = ile_pkg::ST_OK;
    count_nxt         = count_r;
    unique case (in_data.mode)
      ile_pkg::MODE_INSERT: begin
        if (full) begin
          exe_status_nxt = ile_pkg::ST_FULL;
        end else begin
          exe_cmd_nxt.wr_en = 1'b1;
          exe_cmd_nxt.kind  = ile_pkg::SHIFT_INSERT;
          exe_cmd_nxt.pos   = ile_pkg::IDX_W'(ins_pos);
          count_nxt         = count_r + 1'b1;
        end
      end
      ile_pkg::MODE_REMOVE: begin
        if (empty) begin
          exe_status_nxt = ile_pkg::ST_EMPTY;
        end else begin
          exe_cmd_nxt.wr_en = 1'b1;
          exe_cmd_nxt.kind  = ile_pkg::SHIFT_REMOVE;
          exe_cmd_nxt.pos   = ile_pkg::IDX_W'(rm_pos);
          exe_rd_nxt        = 1'b1;
          count_nxt         = count_r - 1'b1;
        end
      end
      ile_pkg::MODE_PEEK: begin
        if (empty) begin
          exe_status_nxt = ile_pkg::ST_EMPTY;
        end else begin
          exe_cmd_nxt.pos = ile_pkg::IDX_W'(rm_pos);
          exe_rd_nxt      = 1'b1;
        end
      end
      default: begin
        // unused mode: no operation
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      exe_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r <= count_nxt;
      end
      exe_valid_r <= in_acc;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Decode stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      exe_cmd_r    <= exe_cmd_nxt;
      exe_rd_r     <= exe_rd_nxt;
      exe_status_r <= exe_status_nxt;
      exe_len_r    <= 7'(count_nxt);
    end
  end

  // Shift only in the cycle the decoded transaction executes
  always_comb begin
    chain_cmd       = exe_cmd_r;
    chain_cmd.wr_en = exe_cmd_r.wr_en & exe_valid_r;
  end

  ile_chain u_chain (
    .clk     (clk),
    .cmd     (chain_cmd),
    .rd_data (chain_rd)
  );

  // Output register
  assign out_valid_nxt = exe_valid_r | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (exe_valid_r) begin
      out_data_r.read_value  <= exe_rd_r ? chain_rd : '0;
      out_data_r.status      <= exe_status_r;
      out_data_r.list_length <= exe_len_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `include "indexed_list_engine_assert.svh"

  `ILE_ASSERT_IMP(a_count_cap, 1'b1, count_r <= ile_pkg::CNT_W'(ile_pkg::CAPACITY))
  `ILE_ASSERT_NEXT(a_exe_to_out, exe_valid_r, out_valid_r)
  `ILE_ASSERT_IMP(a_full_len, out_valid_r && out_data_r.status == ile_pkg::ST_FULL, out_data_r.list_length == 7'(ile_pkg::CAPACITY))
  `ILE_ASSERT_NEXT(a_insert_grow, in_acc && in_data.mode == ile_pkg::MODE_INSERT && !full, count_r == $past(count_r) + ile_pkg::CNT_W'(1))

endmodule
